@@ rtl/lgms_pkg.sv @@
// Shared constants and types of the grid local-minimum risk-sum block.
`default_nettype none

package lgms_pkg;

  // Grid limits and field widths.
  localparam int MAX_COLUMNS = 128;
  localparam int MAX_ROWS    = 128;
  localparam int HEIGHT_BITS = 4;
  localparam int COL_BITS    = $clog2(MAX_COLUMNS);
  localparam int ROW_BITS    = $clog2(MAX_ROWS);
  localparam int SIZE_BITS   = 8;
  localparam int RISK_BITS   = 18;
  localparam int COUNT_BITS  = 15;
  localparam int CFG_IDX_BITS = 2;

  localparam logic [RISK_BITS-1:0]  RISK_MAX  = {RISK_BITS{1'b1}};
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef logic [HEIGHT_BITS-1:0] height_t;
  typedef logic [COL_BITS-1:0]    col_t;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_BITS-1:0] {
    REG_COLUMNS = 2'd0,
    REG_ROWS    = 2'd1
  } cfg_reg_t;

  // Line buffer taps around the column being decided.
  typedef struct packed {
    height_t prev_c;
    height_t prev_cp1;
    height_t prev_cm2;
    height_t rbp_c;
    height_t rbp_cm1;
  } lgms_taps_t;

endpackage

`default_nettype wire

@@ rtl/lgms_if.sv @@
// Valid/ready channel interfaces for samples, results and configuration.
`default_nettype none

interface lgms_in_if import lgms_pkg::*; ();
  logic    valid;
  logic    ready;
  height_t height;
  logic    frame_start;

  modport source (output valid, output height, output frame_start, input ready);
  modport sink   (input valid, input height, input frame_start, output ready);
  modport mon    (input valid, input height, input frame_start, input ready);
endinterface

interface lgms_out_if import lgms_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [RISK_BITS-1:0]  risk_sum;
  logic [COUNT_BITS-1:0] low_count;

  modport source (output valid, output risk_sum, output low_count, input ready);
  modport sink   (input valid, input risk_sum, input low_count, output ready);
  modport mon    (input valid, input risk_sum, input low_count, input ready);
endinterface

interface lgms_cfg_if import lgms_pkg::*; ();
  logic                    valid;
  logic                    ready;
  logic [CFG_IDX_BITS-1:0] index;
  logic [SIZE_BITS-1:0]    data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
  modport mon    (input valid, input index, input data, input ready);
endinterface

`default_nettype wire

@@ rtl/lgms_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lgms_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 128,
  localparam int ADDR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [ADDR_BITS-1:0] waddr,
  input  wire logic [WIDTH-1:0]     wdata,
  input  wire logic                 re,
  input  wire logic [ADDR_BITS-1:0] raddr,
  output logic      [WIDTH-1:0]     rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port; a read in the same cycle as a write to that address sees the old word.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/lgms_linebuf.sv @@
// Two-row line buffer with five read taps and write-to-read forwarding.
`default_nettype none

module lgms_linebuf import lgms_pkg::*; (
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    rd_en,
  input  wire col_t    rd_col,
  input  wire logic    wr_en,
  input  wire col_t    wr_col,
  input  wire height_t wr_height,
  output lgms_taps_t   taps
);

  localparam int NPORTS = 5;
  localparam int P_PREV_C   = 0;
  localparam int P_PREV_CP1 = 1;
  localparam int P_PREV_CM2 = 2;
  localparam int P_RBP_C    = 3;
  localparam int P_RBP_CM1  = 4;

  col_t    rd_addr [NPORTS];
  height_t ram_q   [NPORTS];
  height_t eff     [NPORTS];
  logic    hit_r   [NPORTS];
  height_t fwd_r   [NPORTS];
  height_t rbp_wdata;

  // Read addresses around the column of the incoming sample.
  assign rd_addr[P_PREV_C]   = rd_col;
  assign rd_addr[P_PREV_CP1] = rd_col + col_t'(1);
  assign rd_addr[P_PREV_CM2] = rd_col - col_t'(2);
  assign rd_addr[P_RBP_C]    = rd_col;
  assign rd_addr[P_RBP_CM1]  = rd_col - col_t'(1);

  // The upper line takes the old word of the lower line at the same column.
  assign rbp_wdata = eff[P_PREV_C];

  // One RAM copy per read tap; all copies of a line see the same writes.
  for (genvar p = 0; p < NPORTS; p++) begin : g_port
    localparam bit IS_PREV = (p < P_RBP_C);

    lgms_ram #(
      .WIDTH (HEIGHT_BITS),
      .DEPTH (MAX_COLUMNS)
    ) u_ram (
      .clk   (clk),
      .we    (wr_en),
      .waddr (wr_col),
      .wdata (IS_PREV ? wr_height : rbp_wdata),
      .re    (rd_en),
      .raddr (rd_addr[p]),
      .rdata (ram_q[p])
    );

    // Capture a write that lands on the read address at the same edge.
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        hit_r[p] <= 1'b0;
      end else if (rd_en) begin
        hit_r[p] <= wr_en && (wr_col == rd_addr[p]);
      end
    end

    always_ff @(posedge clk) begin
      if (rd_en) begin
        fwd_r[p] <= IS_PREV ? wr_height : rbp_wdata;
      end
    end

    assign eff[p] = hit_r[p] ? fwd_r[p] : ram_q[p];
  end

  assign taps.prev_c   = eff[P_PREV_C];
  assign taps.prev_cp1 = eff[P_PREV_CP1];
  assign taps.prev_cm2 = eff[P_PREV_CM2];
  assign taps.rbp_c    = eff[P_RBP_C];
  assign taps.rbp_cm1  = eff[P_RBP_CM1];

endmodule

`default_nettype wire

@@ rtl/grid_local_minimum_risk_sum.sv @@
// Top level of the streaming 4-neighbour local-minimum detector with risk sum.
//
// Height samples enter in raster order, one word per clock when both sides
// keep up; a word is accepted whenever the decision stage is empty or moving,
// also while a finished result waits in the output register. The line buffer
// RAMs are read at the edge that accepts a word; the decision stage register
// then holds the word while it does the compare, add and saturate, and the
// result register is loaded when the decision stage moves on with the last
// sample of a frame. The input stalls only while a result waits untaken and
// the decision stage holds the last sample of the next frame. A result word
// carrying the risk sum and the low-point count leaves after the last sample
// of a frame; other samples give no result. The frame size comes from
// columns_in_use (index 0) and rows_in_use (index 1); zero acts as one and
// values above 128 act as 128. The configuration port is always ready and
// should be written only while no sample is in flight. No clearing pass
// follows reset.
`default_nettype none

module grid_local_minimum_risk_sum import lgms_pkg::*; (
  input wire logic   clk,
  input wire logic   rst_n,
  lgms_in_if.sink    in_ch,
  lgms_out_if.source out_ch,
  lgms_cfg_if.sink   cfg_ch
);

  typedef logic [ROW_BITS-1:0] row_t;

  // Sample in the decision stage.
  typedef struct packed {
    height_t h;
    logic    fs;
    col_t    c;
    logic    c_ge1;
    logic    c_ge2;
    logic    r_ge1;
    logic    r_ge2;
    logic    last_col;
    logic    last_row;
  } stage_t;

  // True when v is strictly below every neighbor that exists.
  function automatic logic is_low(
    input height_t v,
    input logic hu, input height_t u,
    input logic hl, input height_t l,
    input logic hr, input height_t rr,
    input logic hd, input height_t d
  );
    is_low = (!hu || (v < u)) && (!hl || (v < l)) &&
             (!hr || (v < rr)) && (!hd || (v < d));
  endfunction

  logic [SIZE_BITS-1:0] cols_r, rows_r;
  col_t       ncol_m1, col_r, col_base, c_a, col_nxt;
  row_t       nrow_m1, row_r, row_base, r_a, row_nxt;
  logic       last_col_a, last_row_a;
  logic       accept, in_ready;
  logic       b_valid_r, b_fire, emit;
  stage_t     b_r, b_nxt;
  lgms_taps_t taps;
  height_t    lts0_r, lts1_r;
  logic       d1, d2, d3;
  logic [HEIGHT_BITS:0]   add1, add2, add3;
  logic [HEIGHT_BITS+1:0] risk_add;
  logic [1:0]             cnt_add;
  logic [RISK_BITS-1:0]   acc_r, acc_base, acc_sat;
  logic [RISK_BITS:0]     acc_full;
  logic [COUNT_BITS-1:0]  cnt_r, cnt_base, cnt_sat;
  logic [COUNT_BITS:0]    cnt_full;
  logic                   out_valid_r;
  logic [RISK_BITS-1:0]   out_risk_r;
  logic [COUNT_BITS-1:0]  out_cnt_r;

  // Configuration registers; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cols_r <= SIZE_BITS'(MAX_COLUMNS);
      rows_r <= SIZE_BITS'(MAX_ROWS);
    end else if (cfg_ch.valid) begin
      case (cfg_ch.index)
        REG_COLUMNS: cols_r <= cfg_ch.data;
        REG_ROWS:    rows_r <= cfg_ch.data;
        default:     ;
      endcase
    end
  end

  assign cfg_ch.ready = 1'b1;

  // Clamp the frame size to the supported range, kept as last index.
  always_comb begin
    if (cols_r == '0) begin
      ncol_m1 = '0;
    end else if (32'(cols_r) > MAX_COLUMNS) begin
      ncol_m1 = col_t'(MAX_COLUMNS - 1);
    end else begin
      ncol_m1 = col_t'(cols_r - SIZE_BITS'(1));
    end
    if (rows_r == '0) begin
      nrow_m1 = '0;
    end else if (32'(rows_r) > MAX_ROWS) begin
      nrow_m1 = row_t'(MAX_ROWS - 1);
    end else begin
      nrow_m1 = row_t'(rows_r - SIZE_BITS'(1));
    end
  end

  // Raster position of the incoming sample.
  assign col_base   = in_ch.frame_start ? '0 : col_r;
  assign row_base   = in_ch.frame_start ? '0 : row_r;
  assign c_a        = (col_base > ncol_m1) ? ncol_m1 : col_base;
  assign r_a        = (row_base > nrow_m1) ? nrow_m1 : row_base;
  assign last_col_a = (c_a == ncol_m1);
  assign last_row_a = (r_a == nrow_m1);

  always_comb begin
    col_nxt = last_col_a ? '0 : c_a + col_t'(1);
    row_nxt = r_a;
    if (last_col_a) begin
      row_nxt = last_row_a ? '0 : r_a + row_t'(1);
    end
  end

  always_comb begin
    b_nxt.h        = in_ch.height;
    b_nxt.fs       = in_ch.frame_start;
    b_nxt.c        = c_a;
    b_nxt.c_ge1    = (c_a != '0);
    b_nxt.c_ge2    = (c_a > col_t'(1));
    b_nxt.r_ge1    = (r_a != '0);
    b_nxt.r_ge2    = (r_a > row_t'(1));
    b_nxt.last_col = last_col_a;
    b_nxt.last_row = last_row_a;
  end

  // Handshake between the input, the decision stage and the output register.
  assign emit     = b_r.last_col && b_r.last_row;
  assign b_fire   = b_valid_r && (!emit || !out_valid_r || out_ch.ready);
  assign in_ready = !b_valid_r || b_fire;
  assign accept   = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r     <= '0;
      row_r     <= '0;
      b_valid_r <= 1'b0;
    end else begin
      if (accept) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      if (accept) begin
        b_valid_r <= 1'b1;
      end else if (b_fire) begin
        b_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_r <= b_nxt;
    end
  end

  // Line buffers: read at acceptance, written when the decision stage moves.
  lgms_linebuf u_linebuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .rd_en     (accept),
    .rd_col    (c_a),
    .wr_en     (b_fire),
    .wr_col    (b_r.c),
    .wr_height (b_r.h),
    .taps      (taps)
  );

  // Decisions: the cell above, on the bottom row the left cell, and in the last cell the current cell.
  assign d1 = b_r.r_ge1 &&
              is_low(taps.prev_c, b_r.r_ge2, taps.rbp_c, b_r.c_ge1, lts0_r,
                     !b_r.last_col, taps.prev_cp1, 1'b1, b_r.h);
  assign d2 = b_r.last_row && b_r.c_ge1 &&
              is_low(lts1_r, b_r.r_ge1, taps.rbp_cm1, b_r.c_ge2, taps.prev_cm2,
                     1'b1, b_r.h, 1'b0, '0);
  assign d3 = b_r.last_row && b_r.last_col &&
              is_low(b_r.h, b_r.r_ge1, taps.prev_c, b_r.c_ge1, lts1_r,
                     1'b0, '0, 1'b0, '0);

  // Risk terms and saturating totals.
  assign add1     = d1 ? {1'b0, taps.prev_c} + (HEIGHT_BITS+1)'(1) : '0;
  assign add2     = d2 ? {1'b0, lts1_r} + (HEIGHT_BITS+1)'(1) : '0;
  assign add3     = d3 ? {1'b0, b_r.h} + (HEIGHT_BITS+1)'(1) : '0;
  assign risk_add = (HEIGHT_BITS+2)'(add1) + (HEIGHT_BITS+2)'(add2) +
                    (HEIGHT_BITS+2)'(add3);
  assign cnt_add  = 2'(d1) + 2'(d2) + 2'(d3);

  assign acc_base = b_r.fs ? '0 : acc_r;
  assign cnt_base = b_r.fs ? '0 : cnt_r;
  assign acc_full = {1'b0, acc_base} + (RISK_BITS+1)'(risk_add);
  assign cnt_full = {1'b0, cnt_base} + (COUNT_BITS+1)'(cnt_add);
  assign acc_sat  = (acc_full > (RISK_BITS+1)'(RISK_MAX)) ? RISK_MAX
                                                          : acc_full[RISK_BITS-1:0];
  assign cnt_sat  = (cnt_full > (COUNT_BITS+1)'(COUNT_MAX)) ? COUNT_MAX
                                                            : cnt_full[COUNT_BITS-1:0];

  // Running state of the decision stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_r  <= '0;
      cnt_r  <= '0;
      lts0_r <= '0;
      lts1_r <= '0;
    end else if (b_fire) begin
      acc_r  <= emit ? '0 : acc_sat;
      cnt_r  <= emit ? '0 : cnt_sat;
      lts0_r <= taps.prev_c;
      lts1_r <= b_r.h;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (b_fire && emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_fire && emit) begin
      out_risk_r <= acc_sat;
      out_cnt_r  <= cnt_sat;
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.risk_sum  = out_risk_r;
  assign out_ch.low_count = out_cnt_r;

endmodule

`default_nettype wire

@@ rtl/lgms_checker.sv @@
// Port-level checks of the local-minimum block, bound to its top level.
`default_nettype none

module lgms_checker import lgms_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_valid,
  input wire logic                  in_ready,
  input wire logic                  out_valid,
  input wire logic                  out_ready,
  input wire logic [RISK_BITS-1:0]  out_risk_sum,
  input wire logic [COUNT_BITS-1:0] out_low_count,
  input wire logic                  cfg_valid,
  input wire logic                  cfg_ready
);

  localparam int CMP_BITS = 32;

  // A result that is not taken holds its word.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_risk_sum) &&
      $stable(out_low_count))
    else $error("result changed while stalled");

  // Each low point adds between one and the largest height plus one.
  a_sum_bounds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |->
      (CMP_BITS'(out_risk_sum) >= CMP_BITS'(out_low_count)) &&
      (CMP_BITS'(out_risk_sum) <= (CMP_BITS'(out_low_count) << HEIGHT_BITS)))
    else $error("risk sum inconsistent with low-point count");

  // A new result follows an accepted sample, registered in the decision stage and then in the output register.
  a_out_cause: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a sample");

  // The input only back-pressures while a result waits untaken.
  a_in_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> out_valid && !out_ready)
    else $error("input stalled without a waiting result");

  // The configuration port never back-pressures.
  a_cfg_ready: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid |-> cfg_ready)
    else $error("configuration write stalled");

endmodule

bind grid_local_minimum_risk_sum lgms_checker u_lgms_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .out_risk_sum  (out_ch.risk_sum),
  .out_low_count (out_ch.low_count),
  .cfg_valid     (cfg_ch.valid),
  .cfg_ready     (cfg_ch.ready)
);

`default_nettype wire
